>>> src/scti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_pkg
// Shared constants, types and table-building functions for the sine/cosine
// table interpolator.
// ----------------------------------------------------------------------------
package scti_pkg;

  localparam int ANGLE_W = 16;
  localparam int VALUE_W = 16;

  // Added to the angle for cosine
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  localparam logic KIND_SINE   = 1'b0;
  localparam logic KIND_COSINE = 1'b1;

  // pi/2 in Q62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam int          SERIES_TERMS = 13;
  localparam logic [15:0] FULL_SCALE = 16'd32767;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } back_status_t;

  // (a * b) >> 62 with a full 128-bit product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, used only to build the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(32767 * sin(x)) for x in Q62, 0 <= x <= pi/2, by a Taylor series
  function automatic logic [15:0] scaled_sine(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] x2;
    logic [63:0] div;
    logic [63:0] scaled;
    sum  = x;
    term = x;
    x2   = mul_q62(x, x);
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      div  = 64'((2 * k) * (2 * k + 1));
      term = udiv64(mul_q62(term, x2), div);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    scaled = ((sum >> 20) * 64'd32767) + (64'd1 << 41);
    return scaled[57:42];
  endfunction

  // Entry r of the quarter-wave table for a table of 2^ib steps per turn
  function automatic logic [15:0] quarter_value(input int ib, input int r);
    logic [63:0] step;
    step = HALF_PI_Q62 >> (ib - 2);
    if (r == (1 << (ib - 2))) begin
      return FULL_SCALE;
    end
    return scaled_sine(step * 64'(r));
  endfunction

endpackage

>>> src/sine_cosine_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_table_interpolator
// Sine or cosine of a 16-bit angle by quarter-wave table lookup and linear
// interpolation, signed Q15 result.
//
//   channel | handshake           | fields
//   --------+---------------------+----------------------------
//   input   | in_valid, in_stall  | kind (1), angle (16)
//   output  | out_valid, out_stall| value (16, signed)
//
// One item per cycle while out_stall does not hold the output; an accepted item
// passes the queue register, table stage, multiply stage and output register.
// in_stall is high only while the 4-entry queue is full.
// The back pipe holds as a whole while out_stall holds a result.
// Reset empties the queue and the pipe; the table is constant logic.
// ----------------------------------------------------------------------------
module sine_cosine_table_interpolator #(
  parameter int INDEX_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [scti_pkg::ANGLE_W-1:0]        angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [scti_pkg::VALUE_W-1:0] value
);
  import scti_pkg::*;

  localparam int ENTRY_W = INDEX_BITS + 16;
  localparam int Q_DEPTH = 4;

  logic [ENTRY_W-1:0] f_entry;
  logic [ENTRY_W-1:0] q_data;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  back_status_t       b_status;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  scti_front #(
    .INDEX_BITS(INDEX_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .kind (kind),
    .angle(angle),
    .entry(f_entry)
  );

  scti_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(f_entry),
    .pop      (q_pop),
    .pop_data (q_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  scti_back #(
    .INDEX_BITS(INDEX_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .status   (b_status)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_empty)
    else $error("queue full and empty at once");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_status.b_valid))
    else $error("result appeared without an item in the multiply stage");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value != 16'sh8000)
    else $error("result outside the Q15 range");
`endif

endmodule

>>> src/scti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_front
// Classifies an item: applies the cosine offset, splits index and fraction,
// and folds both neighbor indexes onto the quarter-wave table with a sign.
// ----------------------------------------------------------------------------
module scti_front #(
  parameter int INDEX_BITS = 8,
  parameter int ENTRY_W    = INDEX_BITS + 16
) (
  input  logic                         kind,
  input  logic [scti_pkg::ANGLE_W-1:0] angle,
  output logic [ENTRY_W-1:0]           entry
);
  import scti_pkg::*;

  localparam int FRAC_BITS = ANGLE_W - INDEX_BITS;
  localparam int ADDR_W    = INDEX_BITS - 1;
  localparam logic [ADDR_W-1:0] QUARTER = ADDR_W'(1) << (INDEX_BITS - 2);

  logic [ANGLE_W-1:0]    turned;
  logic [INDEX_BITS-1:0] idx0;
  logic [INDEX_BITS-1:0] idx1;
  logic [FRAC_BITS-1:0]  frac;
  logic [ADDR_W-1:0]     addr0;
  logic [ADDR_W-1:0]     addr1;
  logic                  neg0;
  logic                  neg1;

  always_comb begin
    turned = (kind == KIND_COSINE) ? angle + QUARTER_TURN : angle;
    idx0   = turned[ANGLE_W-1:FRAC_BITS];
    frac   = turned[FRAC_BITS-1:0];
    // last segment wraps to entry 0, which equals the extra end entry
    idx1   = idx0 + INDEX_BITS'(1);
  end

  // odd quadrants mirror the quarter table, the upper half negates
  always_comb begin
    addr0 = idx0[INDEX_BITS-2] ? QUARTER - {1'b0, idx0[INDEX_BITS-3:0]}
                               : {1'b0, idx0[INDEX_BITS-3:0]};
    addr1 = idx1[INDEX_BITS-2] ? QUARTER - {1'b0, idx1[INDEX_BITS-3:0]}
                               : {1'b0, idx1[INDEX_BITS-3:0]};
    neg0  = idx0[INDEX_BITS-1];
    neg1  = idx1[INDEX_BITS-1];
    entry = {neg1, addr1, neg0, addr0, frac};
  end

endmodule

>>> src/scti_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module scti_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import scti_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/scti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_back
// Table lookup, interpolation multiply and rounding, three register stages
// ending in the output register.
// ----------------------------------------------------------------------------
module scti_back #(
  parameter int INDEX_BITS = 8,
  parameter int ENTRY_W    = INDEX_BITS + 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  logic [ENTRY_W-1:0]                  q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [scti_pkg::VALUE_W-1:0] value,
  output scti_pkg::back_status_t              status
);
  import scti_pkg::*;

  localparam int FRAC_BITS = ANGLE_W - INDEX_BITS;
  localparam int ADDR_W    = INDEX_BITS - 1;
  localparam int QUARTER   = 1 << (INDEX_BITS - 2);
  localparam int DIFF_W    = VALUE_W + 1;
  localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;
  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) << (FRAC_BITS - 1);

  logic [VALUE_W-1:0] qtab [QUARTER + 1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
    localparam logic [VALUE_W-1:0] QV = quarter_value(INDEX_BITS, g);
    assign qtab[g] = QV;
  end

  logic [FRAC_BITS-1:0] frac;
  logic [ADDR_W-1:0]    addr0;
  logic [ADDR_W-1:0]    addr1;
  logic                 neg0;
  logic                 neg1;
  logic                 advance;

  assign {neg1, addr1, neg0, addr0, frac} = q_data;

  // whole pipe moves unless the output register is held
  assign advance = !out_valid || !out_stall;
  assign q_pop   = advance && !q_empty;

  // stage A: table values
  logic                      a_valid;
  logic signed [VALUE_W-1:0] a_v0;
  logic signed [VALUE_W-1:0] a_v1;
  logic [FRAC_BITS-1:0]      a_frac;

  // stage B: interpolation product
  logic                      b_valid;
  logic signed [VALUE_W-1:0] b_v0;
  logic signed [PROD_W-1:0]  b_prod;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [PROD_W-1:0]  step;
  logic [VALUE_W-1:0]        value_next;

  always_comb begin
    diff       = DIFF_W'(a_v1) - DIFF_W'(a_v0);
    prod_next  = PROD_W'(diff) * PROD_W'($signed({1'b0, a_frac}));
    rounded    = b_prod + ROUND;
    step       = rounded >>> FRAC_BITS;
    value_next = b_v0 + step[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= !q_empty;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_v0   <= neg0 ? -qtab[addr0] : qtab[addr0];
      a_v1   <= neg1 ? -qtab[addr1] : qtab[addr1];
      a_frac <= frac;
      b_v0   <= a_v0;
      b_prod <= prod_next;
      value  <= value_next;
    end
  end

  assign status.a_valid = a_valid;
  assign status.b_valid = b_valid;

endmodule

>>> sim/sincos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sincos_checker
// Watches both channels of the sine/cosine interpolator. It computes the
// expected Q15 value for every accepted angle from its own copy of the sine
// table, then compares each accepted result with the oldest expected value.
// ----------------------------------------------------------------------------
module sincos_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                kind,
  input  logic [scti_pkg::ANGLE_W-1:0]        angle,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [scti_pkg::VALUE_W-1:0] value,
  output int                                  errors,
  output int                                  pending
);
  import scti_pkg::*;

  localparam int          TABLE_STEPS   = 256;
  localparam int          QUARTER_STEPS = TABLE_STEPS / 4;
  localparam int          FRAC_W        = 8;
  localparam logic [63:0] RIGHT_ANGLE_Q62 = 64'h6487ED5110B4611A;

  int                        sine_table [0:TABLE_STEPS];
  logic signed [VALUE_W-1:0] expected_values [$];
  logic signed [VALUE_W-1:0] want;

  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[125:62];
  endfunction

  // round(32767 * sin(x)) for x in Q62 within the first quarter turn
  function automatic int rounded_sine(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] x2;
    logic [63:0] scaled;
    sum  = x;
    term = x;
    x2   = q62_product(x, x);
    for (int k = 1; k <= 13; k++) begin
      term = q62_product(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    scaled = (sum >> 20) * 64'd32767 + (64'd1 << 41);
    return int'(scaled >> 42);
  endfunction

  function automatic logic signed [VALUE_W-1:0] interpolated_value(
    input logic k, input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] turned;
    int                 seg;
    int                 base;
    int                 delta;
    int                 res;
    // cosine is sine a quarter turn ahead, wrapping at the full turn
    turned = (k == KIND_COSINE) ? a + QUARTER_TURN : a;
    seg    = int'(turned[ANGLE_W-1:FRAC_W]);
    base   = sine_table[seg];
    delta  = (sine_table[seg + 1] - base) * int'(turned[FRAC_W-1:0]);
    res    = base + ((delta + (1 << (FRAC_W - 1))) >>> FRAC_W);
    return res[VALUE_W-1:0];
  endfunction

  initial begin
    int          quarter [0:QUARTER_STEPS];
    logic [63:0] step;
    errors = 0;
    step   = RIGHT_ANGLE_Q62 >> 6;
    for (int i = 0; i <= QUARTER_STEPS; i++) begin
      quarter[i] = (i == QUARTER_STEPS) ? 32767 : rounded_sine(step * 64'(i));
    end
    // unfold the quarter wave; the extra last entry equals entry 0
    for (int i = 0; i <= TABLE_STEPS; i++) begin
      case (i / QUARTER_STEPS)
        0: sine_table[i] = quarter[i % QUARTER_STEPS];
        1: sine_table[i] = quarter[QUARTER_STEPS - i % QUARTER_STEPS];
        2: sine_table[i] = -quarter[i % QUARTER_STEPS];
        3: sine_table[i] = -quarter[QUARTER_STEPS - i % QUARTER_STEPS];
        default: sine_table[i] = 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_values.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0d", $time, value);
        end else begin
          want = expected_values.pop_front();
          if (value !== want) begin
            errors++;
            $display("%0t: value mismatch, expected %0d, actual %0d", $time, want, value);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_values.push_back(interpolated_value(kind, angle));
      end
      pending <= expected_values.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the sine/cosine interpolator test. Drives directed angles at the
// table edges and quarter points, then random angles in bursts, while the
// result side stalls in changing patterns. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb;
  import scti_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic                      kind      = KIND_SINE;
  logic [ANGLE_W-1:0]        angle     = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] value;
  int                        errors;
  int                        pending;
  int                        stall_mode = STALL_NONE;
  int                        stall_left = 0;

  always #5 clk = ~clk;

  sine_cosine_table_interpolator u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .angle     (angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value)
  );

  sincos_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .angle     (angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .errors    (errors),
    .pending   (pending)
  );

  // Result side: switch between no stall, light and heavy stall stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
        stall_left = $urandom_range(5, 60);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_angle(input logic k, input logic [ANGLE_W-1:0] a);
    in_valid <= 1'b1;
    kind     <= k;
    angle    <= a;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    logic [7:0] seg;
    seg = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 15))
      0:       return {seg, 8'h00};
      1:       return {seg, 8'hFF};
      2:       return {seg, 8'h80};
      3:       return {8'hFF, 8'($urandom_range(0, 255))};
      default: return ANGLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int burst_left;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // quarter points, table ends, fraction extremes, cosine wrap
    send_angle(KIND_SINE,   16'h0000);
    send_angle(KIND_SINE,   16'h4000);
    send_angle(KIND_SINE,   16'h8000);
    send_angle(KIND_SINE,   16'hC000);
    send_angle(KIND_SINE,   16'hFFFF);
    send_angle(KIND_SINE,   16'h00FF);
    send_angle(KIND_SINE,   16'hFF00);
    send_angle(KIND_SINE,   16'hFF80);
    send_angle(KIND_SINE,   16'h3FFF);
    send_angle(KIND_SINE,   16'h7F80);
    send_angle(KIND_SINE,   16'h5555);
    send_angle(KIND_COSINE, 16'h0000);
    send_angle(KIND_COSINE, 16'h4000);
    send_angle(KIND_COSINE, 16'h8000);
    send_angle(KIND_COSINE, 16'hBFFF);
    send_angle(KIND_COSINE, 16'hBF80);
    send_angle(KIND_COSINE, 16'hC000);
    send_angle(KIND_COSINE, 16'hFFFF);
    send_angle(KIND_COSINE, 16'hFF00);
    send_angle(KIND_COSINE, 16'h3F80);
    send_angle(KIND_COSINE, 16'hAAAA);
    drain_results();

    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          pause_sender($urandom_range(1, 6));
        end
      end
      send_angle(1'($urandom_range(0, 1)), random_angle());
      burst_left--;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
